[sv/common_divisor_nearest_target_top_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef COMMON_DIVISOR_NEAREST_TARGET_TOP_ASSERT_SVH
`define COMMON_DIVISOR_NEAREST_TARGET_TOP_ASSERT_SVH

// Same-cycle implication.
`define CDNT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cdnt_pkg.sv]
// ---------------------------------------------------------------------------
// cdnt_pkg
// Shared constants, controller states and the command and status bundles
// that join the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdnt_pkg;

  // Default operand width and the fixed width of the target register.
  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned TARGET_WIDTH    = 16;
  localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = 16'd60;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_SCAN_CHK,
    ST_SCAN_DIV,
    ST_CAND_HI,
    ST_FINISH
  } cdnt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the operands of a new item
    logic div_start;   // start the serial divider on x
    logic div_sel_i;   // divisor is the trial index (else the gcd partner y)
    logic gcd_update;  // Euclid step: x <= y, y <= remainder
    logic scan_init;   // i = 1, square = 1, clear the best candidate
    logic cand_lo;     // examine the trial index as a candidate
    logic cand_hi;     // examine the quotient as a candidate
    logic scan_next;   // advance the trial index and its square
    logic out_load;    // move the best candidate to the output register
  } cdnt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_zero;      // Euclid partner is zero, x holds the gcd
    logic sq_le_g;     // i*i <= gcd
    logic div_busy;    // divider still iterating
    logic rem_zero;    // last division left no remainder
    logic quo_ne_i;    // quotient differs from the trial index
    logic out_free;    // output register can take a new item
  } cdnt_status_t;

endpackage

`default_nettype wire

[sv/cdnt_in_if.sv]
// ---------------------------------------------------------------------------
// cdnt_in_if
// Input channel: two operands per item under a valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdnt_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] first_value;
  logic [VALUE_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

`default_nettype wire

[sv/cdnt_out_if.sv]
// ---------------------------------------------------------------------------
// cdnt_out_if
// Output channel: nearest common divisor and error flag per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdnt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] nearest_factor;
  logic        no_divisor_error;

  modport source (output valid, output nearest_factor, output no_divisor_error, input ready);
  modport sink   (input valid, input nearest_factor, input no_divisor_error, output ready);
endinterface

`default_nettype wire

[sv/cdnt_divider.sv]
// ---------------------------------------------------------------------------
// cdnt_divider
// Restoring radix-2 divider: one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdnt_divider #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                        busy_o,
  output logic [VALUE_WIDTH-1:0]      quotient_o,
  output logic [VALUE_WIDTH-1:0]      remainder_o
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] dvs_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_q, quo_q[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
    quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
    cnt_d = cnt_q - CW'(1);
  end

  // Iteration counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(VALUE_WIDTH);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  // Partial remainder, quotient and divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[sv/cdnt_controller.sv]
// ---------------------------------------------------------------------------
// cdnt_controller
// Sequencer: Euclid loop, then the divisor scan, then the result handoff.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdnt_controller
  import cdnt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire cdnt_status_t status_i,
  output cdnt_cmd_t         cmd_o
);

  cdnt_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_GCD_CHK;
        end
      end
      ST_GCD_CHK: begin
        if (status_i.y_zero) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN_CHK;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_GCD_DIV;
        end
      end
      ST_GCD_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.gcd_update = 1'b1;
          state_d          = ST_GCD_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (status_i.sq_le_g) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_i = 1'b1;
          state_d         = ST_SCAN_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN_DIV: begin
        if (!status_i.div_busy) begin
          if (status_i.rem_zero) begin
            cmd_o.cand_lo = 1'b1;
            state_d       = ST_CAND_HI;
          end else begin
            cmd_o.scan_next = 1'b1;
            state_d         = ST_SCAN_CHK;
          end
        end
      end
      ST_CAND_HI: begin
        // The paired divisor is skipped when it equals the index itself.
        cmd_o.cand_hi   = status_i.quo_ne_i;
        cmd_o.scan_next = 1'b1;
        state_d         = ST_SCAN_CHK;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/cdnt_datapath.sv]
// ---------------------------------------------------------------------------
// cdnt_datapath
// Operand registers, target register, scan index, best candidate, the
// shared serial divider and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdnt_datapath
  import cdnt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [TARGET_WIDTH-1:0] cfg_wdata_i,
  input  wire logic [VALUE_WIDTH-1:0]  first_value_i,
  input  wire logic [VALUE_WIDTH-1:0]  second_value_i,
  input  wire cdnt_cmd_t               cmd_i,
  output cdnt_status_t                 status_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [TARGET_WIDTH-1:0]      nearest_factor_o,
  output logic                         no_divisor_error_o
);

  localparam int unsigned DW = (VALUE_WIDTH > TARGET_WIDTH) ? VALUE_WIDTH : TARGET_WIDTH;

  logic [TARGET_WIDTH-1:0] target_q;
  logic [VALUE_WIDTH-1:0]  x_q, y_q;
  logic [VALUE_WIDTH-1:0]  i_q;
  logic [VALUE_WIDTH:0]    sq_q;
  logic [VALUE_WIDTH-1:0]  best_q;
  logic [DW-1:0]           best_dist_q;
  logic                    have_q;
  logic                    out_valid_q;
  logic [TARGET_WIDTH-1:0] out_factor_q;
  logic                    out_err_q;

  logic                    div_busy;
  logic [VALUE_WIDTH-1:0]  quotient;
  logic [VALUE_WIDTH-1:0]  remainder;
  logic [VALUE_WIDTH-1:0]  divisor;
  logic [VALUE_WIDTH-1:0]  cand;
  logic [DW-1:0]           cand_x, target_x, cand_dist;
  logic                    take;

  // Shared divider: Euclid remainders and trial divisions of the gcd.
  assign divisor = cmd_i.div_sel_i ? i_q : y_q;

  cdnt_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (x_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  // Distance of the candidate under test to the target.
  always_comb begin
    cand      = cmd_i.cand_hi ? quotient : i_q;
    cand_x    = DW'(cand);
    target_x  = DW'(target_q);
    cand_dist = (cand_x >= target_x) ? (cand_x - target_x) : (target_x - cand_x);
    take      = (cmd_i.cand_lo && (!have_q || (cand_dist < best_dist_q))) ||
                (cmd_i.cand_hi && (cand_dist < best_dist_q));
  end

  // Target register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Euclid operands; x holds the gcd once y reaches zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= first_value_i;
      y_q <= second_value_i;
    end else if (cmd_i.gcd_update) begin
      x_q <= y_q;
      y_q <= remainder;
    end
  end

  // Trial index and its square, advanced by (i+1)^2 = i^2 + 2i + 1.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      i_q  <= VALUE_WIDTH'(1);
      sq_q <= (VALUE_WIDTH + 1)'(1);
    end else if (cmd_i.scan_next) begin
      i_q  <= i_q + VALUE_WIDTH'(1);
      sq_q <= sq_q + {i_q, 1'b1};
    end
  end

  // Best candidate so far; a tie keeps the earlier one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q      <= '0;
      best_dist_q <= '0;
    end else if (take) begin
      best_q      <= cand;
      best_dist_q <= cand_dist;
    end
  end

  // Output register; a gcd of zero leaves no candidate and flags the error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_factor_q <= TARGET_WIDTH'(best_q);
      out_err_q    <= !have_q;
    end
  end

  // Status toward the controller.
  always_comb begin
    status_o.y_zero   = (y_q == '0);
    status_o.sq_le_g  = (sq_q <= {1'b0, x_q});
    status_o.div_busy = div_busy;
    status_o.rem_zero = (remainder == '0);
    status_o.quo_ne_i = (quotient != i_q);
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o        = out_valid_q;
  assign nearest_factor_o   = out_factor_q;
  assign no_divisor_error_o = out_err_q;

endmodule

`default_nettype wire

[sv/common_divisor_nearest_target_top.sv]
// ---------------------------------------------------------------------------
// common_divisor_nearest_target_top
// Finds the common divisor of two operands that lies nearest to a target.
//
//   Channel  Dir  Payload                                  Handshake
//   in_i     in   first_value, second_value                valid/ready
//   out_o    out  nearest_factor, no_divisor_error         valid/ready
//   cfg      in   cfg_wdata_i (target_factor)              cfg_we_i
//
// One item at a time. Each Euclid step and each trial division runs on the
// single serial divider; the scan tries each index i with i*i <= g, g the gcd.
// A result waits in the output register while the next item is accepted.
// Reset is asynchronous and active low; the target resets to 60.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module common_divisor_nearest_target_top
  import cdnt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  cdnt_in_if.sink                      in_i,
  cdnt_out_if.source                   out_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [TARGET_WIDTH-1:0] cfg_wdata_i
);

  cdnt_cmd_t    cmd;
  cdnt_status_t status;

  // Sequencer.
  cdnt_controller u_controller (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath.
  cdnt_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .first_value_i     (in_i.first_value),
    .second_value_i    (in_i.second_value),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .nearest_factor_o  (out_o.nearest_factor),
    .no_divisor_error_o(out_o.no_divisor_error)
  );

endmodule

`default_nettype wire

[sv/cdnt_checker.sv]
// ---------------------------------------------------------------------------
// cdnt_checker
// Port-level checks of the top level, attached by a bind statement.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "common_divisor_nearest_target_top_assert.svh"

module cdnt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] nearest_factor_i,
  input wire logic        no_divisor_error_i
);

  // An error result always carries a zero factor.
  `CDNT_ASSERT_NOW(a_err_zero, out_valid_i && no_divisor_error_i, nearest_factor_i == 16'd0, "error result with nonzero factor")

  // A stalled result stays put.
  `CDNT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(nearest_factor_i) && $stable(no_divisor_error_i), "stalled result changed")

  // An accepted item occupies the block for at least the next cycle.
  `CDNT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "ready right after accept")

  // No result appears in the cycle right after an item is accepted.
  `CDNT_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_i && !out_valid_i, !out_valid_i, "result too early")

endmodule

bind common_divisor_nearest_target_top cdnt_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .nearest_factor_i  (out_o.nearest_factor),
  .no_divisor_error_i(out_o.no_divisor_error)
);

`default_nettype wire
